[rtl/tsd_pkg.sv]
// ----------------------------------------------------------------------------
// tsd_pkg: shared types and constants of the transport stream demux
// Word layouts of the input and result channels, the queue entry that links
// the classifier to the result sequencer, and the sizing constants.
// ----------------------------------------------------------------------------
package tsd_pkg;

	// Channel count and transport packet length.
	localparam int CHANNEL_COUNT = 4;
	localparam int PACKET_BYTES  = 188;

	// Bytes carried by one micro packet, and the sync byte value.
	localparam int             BYTES_PER_WORD = 3;
	localparam logic [7:0]     SYNC_BYTE      = 8'h47;

	// Channel index width derived from the channel count, and the mask width.
	localparam int CH_IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int MASK_W   = 4;

	// Queue sizing between the classifier and the sequencer.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Input micro packet word.
	typedef struct packed {
		logic [23:0] payload_bytes;
		logic        error_bit;
		logic        start_bit;
		logic [2:0]  seq_counter;
		logic [2:0]  channel_tag;
	} pkt_word_t;

	// Result word, one per emitted byte.
	typedef struct packed {
		logic [1:0] channel;
		logic [7:0] ts_byte;
		logic       packet_first;
		logic       packet_last;
		logic       item_last;
	} res_word_t;

	// One classified micro packet: bytes in processing order plus flags.
	typedef struct packed {
		logic [1:0]                          channel;
		logic [BYTES_PER_WORD-1:0][7:0]      bytes;
		logic [BYTES_PER_WORD-1:0]           emit;
		logic [BYTES_PER_WORD-1:0]           first;
		logic [BYTES_PER_WORD-1:0]           last;
	} q_entry_t;

endpackage

[rtl/tsd_front.sv]
// ----------------------------------------------------------------------------
// tsd_front: micro packet classifier
// Accepts input words, tracks the byte position of each channel and marks
// which of the three bytes are stored, open a packet or close a packet.
// ----------------------------------------------------------------------------
module tsd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pkt_valid,
	output logic                          pkt_stall,
	input  tsd_pkg::pkt_word_t            pkt,
	input  logic [tsd_pkg::MASK_W-1:0]    enable_mask,
	input  logic                          queue_full,
	output logic                          push,
	output tsd_pkg::q_entry_t             entry
);

	localparam logic [7:0] PKT_LEN = 8'(tsd_pkg::PACKET_BYTES);
	localparam logic [2:0] CH_MAX  = 3'(tsd_pkg::CHANNEL_COUNT);

	logic [tsd_pkg::CHANNEL_COUNT-1:0][7:0] pos_q;

	logic                         accept;
	logic                         tag_ok;
	logic [2:0]                   ch;
	logic [tsd_pkg::CH_IDX_W-1:0] ch_idx;
	logic                         enabled;
	logic [7:0]                   pos_final;

	// The queue is the only source of back pressure.
	assign pkt_stall = queue_full;
	assign accept    = pkt_valid && !pkt_stall;

	// Tag decode: tags one through the channel count select a channel.
	assign tag_ok  = (pkt.channel_tag != 3'd0) && (pkt.channel_tag <= CH_MAX);
	assign ch      = pkt.channel_tag - 3'd1;
	assign ch_idx  = ch[tsd_pkg::CH_IDX_W-1:0];
	assign enabled = (ch < 3'd4) && enable_mask[ch[1:0]];

	// Walk the three bytes high byte first, advancing the channel position.
	always_comb begin
		logic [7:0] p;
		logic [7:0] b;
		logic [7:0] inc;
		logic       stored;
		p           = pos_q[ch_idx];
		entry       = '0;
		entry.channel = ch[1:0];
		for (int k = 0; k < tsd_pkg::BYTES_PER_WORD; k++) begin
			b      = pkt.payload_bytes[23 - 8*k -: 8];
			stored = 1'b0;
			inc    = p + 8'd1;
			entry.bytes[k] = b;
			if (p == 8'd0) begin
				if (pkt.start_bit && (b == tsd_pkg::SYNC_BYTE)) begin
					stored         = 1'b1;
					entry.first[k] = 1'b1;
					p              = 8'd1;
				end
			end else begin
				stored = 1'b1;
				if (inc >= PKT_LEN) begin
					entry.last[k] = 1'b1;
					p             = 8'd0;
				end else begin
					p = inc;
				end
			end
			entry.emit[k] = stored && enabled;
		end
		pos_final = p;
	end

	// Only words that give at least one result enter the queue.
	assign push = accept && tag_ok && (|entry.emit);

	// Channel positions advance whether or not the channel is enabled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept && tag_ok) begin
			pos_q[ch_idx] <= pos_final;
		end
	end

endmodule

[rtl/tsd_queue.sv]
// ----------------------------------------------------------------------------
// tsd_queue: classified word queue
// A small first-in first-out store that decouples the classifier from the
// result sequencer.
// ----------------------------------------------------------------------------
module tsd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tsd_pkg::q_entry_t  push_entry,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output tsd_pkg::q_entry_t  head
);

	tsd_pkg::q_entry_t [tsd_pkg::QUEUE_DEPTH-1:0] store_q;

	logic [tsd_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [tsd_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [tsd_pkg::QCNT_W-1:0] count_q;

	assign full  = (count_q == tsd_pkg::QCNT_W'(tsd_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = store_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + tsd_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + tsd_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + tsd_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - tsd_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

[rtl/tsd_back.sv]
// ----------------------------------------------------------------------------
// tsd_back: result sequencer
// Takes classified words from the queue and sends their marked bytes one
// result word per cycle, while res_stall is low, through an output register.
// ----------------------------------------------------------------------------
module tsd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               queue_empty,
	input  tsd_pkg::q_entry_t  head,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_stall,
	output tsd_pkg::res_word_t res
);

	tsd_pkg::q_entry_t  work_q;
	logic               work_valid_q;
	logic [2:0]         rem_q;
	logic               res_valid_q;
	tsd_pkg::res_word_t res_q;

	logic       advance;
	logic       emitting;
	logic [1:0] sel;
	logic [2:0] rem_after;
	logic       word_done;

	// The output register moves when it is empty or being taken.
	assign advance  = !res_valid_q || !res_stall;
	assign emitting = advance && work_valid_q;

	// Lowest remaining marked byte goes next.
	always_comb begin
		if (rem_q[0]) begin
			sel = 2'd0;
		end else if (rem_q[1]) begin
			sel = 2'd1;
		end else begin
			sel = 2'd2;
		end
	end

	assign rem_after = rem_q & ~(3'b001 << sel);
	assign word_done = (rem_after == 3'b000);
	assign pop       = !queue_empty && (!work_valid_q || (emitting && word_done));

	// Working word and its remaining byte marks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_q <= 1'b0;
			rem_q        <= '0;
		end else if (pop) begin
			work_valid_q <= 1'b1;
			rem_q        <= head.emit;
		end else if (emitting && word_done) begin
			work_valid_q <= 1'b0;
			rem_q        <= '0;
		end else if (emitting) begin
			rem_q <= rem_after;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			work_q <= head;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= work_valid_q;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emitting) begin
			res_q.channel      <= work_q.channel;
			res_q.ts_byte      <= work_q.bytes[sel];
			res_q.packet_first <= work_q.first[sel];
			res_q.packet_last  <= work_q.last[sel];
			res_q.item_last    <= word_done;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[rtl/ts_micro_packet_demux_core.sv]
// ----------------------------------------------------------------------------
// ts_micro_packet_demux_core: transport stream micro packet demultiplexer
// Splits 32-bit micro packets into per-channel transport stream bytes with
// packet start and end marks.
//
//   Channel  Direction  Handshake            Word
//   pkt      in         pkt_valid/pkt_stall  pkt_word_t micro packet
//   res      out        res_valid/res_stall  res_word_t one stream byte
//   cfg      in         cfg_valid/cfg_ready  4-bit stream enable mask
//
// A micro packet is accepted whenever the four-entry queue has room; each
// one gives up to three results, sent one per cycle while res_stall is low,
// so the single result port sets the sustained rate. Each result passes
// through the queue, the working word register and the output register.
// Reset clears all channel positions to sync search and the mask to zero.
// The input stalls only when the queue is full.
// ----------------------------------------------------------------------------
module ts_micro_packet_demux_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pkt_valid,
	output logic                       pkt_stall,
	input  tsd_pkg::pkt_word_t         pkt,
	output logic                       res_valid,
	input  logic                       res_stall,
	output tsd_pkg::res_word_t         res,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [tsd_pkg::MASK_W-1:0] cfg_data
);

	logic [tsd_pkg::MASK_W-1:0] enable_mask_q;

	logic              q_push;
	logic              q_pop;
	logic              q_full;
	logic              q_empty;
	tsd_pkg::q_entry_t q_in;
	tsd_pkg::q_entry_t q_head;

	// Enable mask register, always ready for a write word.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			enable_mask_q <= cfg_data;
		end
	end

	// Classifier.
	tsd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pkt_valid   (pkt_valid),
		.pkt_stall   (pkt_stall),
		.pkt         (pkt),
		.enable_mask (enable_mask_q),
		.queue_full  (q_full),
		.push        (q_push),
		.entry       (q_in)
	);

	// Queue between classifier and sequencer.
	tsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.empty      (q_empty),
		.head       (q_head)
	);

	// Result sequencer.
	tsd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (q_empty),
		.head        (q_head),
		.pop         (q_pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res)
	);

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for ts_micro_packet_demux_core
// Drives micro packet words and stream enable masks into the demux, predicts
// every emitted transport stream byte from a private copy of the per-channel
// sync positions, and checks each result word in order. Both handshakes idle
// at random, and the result side also holds off for long stretches.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CLK_PERIOD    = 12;
	localparam int RESET_CYCLES  = 7;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 80;

	// Tracks sync positions per channel and holds the stream bytes still owed.
	class ts_byte_scoreboard;
		logic [tsd_pkg::MASK_W-1:0] enable_mask;
		logic [7:0]                 sync_position [tsd_pkg::CHANNEL_COUNT];
		tsd_pkg::res_word_t         pending_bytes [$];
		int                         mismatch_count;

		function new();
			enable_mask = '0;
			foreach (sync_position[c])
				sync_position[c] = '0;
			mismatch_count = 0;
		endfunction

		function int pending();
			return pending_bytes.size();
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			mismatch_count++;
		endtask

		// Walks the three bytes of an accepted word, high byte first.
		function void note_word(tsd_pkg::pkt_word_t w);
			tsd_pkg::res_word_t produced [tsd_pkg::BYTES_PER_WORD];
			int                 count;
			int                 ch;
			int                 k;
			logic               enabled;
			logic               stored;
			logic               first;
			logic               last;
			logic [7:0]         b;
			logic [7:0]         pos;
			count = 0;
			if (w.channel_tag < 1 || w.channel_tag > tsd_pkg::CHANNEL_COUNT)
				return;
			ch = w.channel_tag - 1;
			enabled = (ch < tsd_pkg::MASK_W) && enable_mask[ch];
			for (k = 0; k < tsd_pkg::BYTES_PER_WORD; k++) begin
				b = w.payload_bytes[23 - 8 * k -: 8];
				pos = sync_position[ch];
				stored = 1'b0;
				first = 1'b0;
				last = 1'b0;
				if (pos == 0) begin
					if (w.start_bit && b == tsd_pkg::SYNC_BYTE) begin
						sync_position[ch] = 8'd1;
						first = 1'b1;
						stored = 1'b1;
					end
				end else begin
					stored = 1'b1;
					if (pos + 1 >= tsd_pkg::PACKET_BYTES) begin
						sync_position[ch] = '0;
						last = 1'b1;
					end else begin
						sync_position[ch] = pos + 8'd1;
					end
				end
				if (stored && enabled) begin
					produced[count].channel = 2'(ch);
					produced[count].ts_byte = b;
					produced[count].packet_first = first;
					produced[count].packet_last = last;
					produced[count].item_last = 1'b0;
					count++;
				end
			end
			for (k = 0; k < count; k++) begin
				if (k == count - 1)
					produced[k].item_last = 1'b1;
				pending_bytes = {pending_bytes, produced[k]};
			end
		endfunction

		// Compares one emitted byte with the oldest one owed.
		task check_ts_byte(tsd_pkg::res_word_t got);
			tsd_pkg::res_word_t want;
			if (pending_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected result ch %0d byte %02h",
					got.channel, got.ts_byte));
				return;
			end
			want = pending_bytes.pop_front();
			if (got.channel !== want.channel)
				report_mismatch($sformatf("channel got %0d want %0d", got.channel,
					want.channel));
			if (got.ts_byte !== want.ts_byte)
				report_mismatch($sformatf("ts_byte got %02h want %02h", got.ts_byte,
					want.ts_byte));
			if (got.packet_first !== want.packet_first)
				report_mismatch($sformatf("packet_first got %b want %b",
					got.packet_first, want.packet_first));
			if (got.packet_last !== want.packet_last)
				report_mismatch($sformatf("packet_last got %b want %b",
					got.packet_last, want.packet_last));
			if (got.item_last !== want.item_last)
				report_mismatch($sformatf("item_last got %b want %b", got.item_last,
					want.item_last));
		endtask
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       pkt_valid;
	logic                       pkt_stall;
	tsd_pkg::pkt_word_t         pkt;
	logic                       res_valid;
	logic                       res_stall = 1'b0;
	tsd_pkg::res_word_t         res;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [tsd_pkg::MASK_W-1:0] cfg_data;

	ts_byte_scoreboard board;
	int                tx_idle_pct = 0;
	int                rx_idle_pct = 0;
	int                hold_requests = 0;
	int                holds_served = 0;
	int                hold_left = 0;
	int                cycle_count = 0;

	ts_micro_packet_demux_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.pkt       (pkt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[ts_micro_packet_demux_core] ERROR");
			$finish;
		end
	end

	// Result side stall: a requested hold-off wins over random idling.
	always @(posedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left--;
		end else begin
			res_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Every result word taken is checked at once.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			board.check_ts_byte(res);
	end

	function automatic tsd_pkg::pkt_word_t pack_word(logic [23:0] payload, logic start,
		logic [2:0] tag, logic err, logic [2:0] seq);
		tsd_pkg::pkt_word_t w;
		w.payload_bytes = payload;
		w.start_bit = start;
		w.channel_tag = tag;
		w.error_bit = err;
		w.seq_counter = seq;
		return w;
	endfunction

	// Mostly words that find sync and run packets to the end on a favored
	// channel; a few are pure noise with any tag.
	function automatic tsd_pkg::pkt_word_t make_packet_word(int focus_ch);
		tsd_pkg::pkt_word_t w;
		logic [7:0]         pos;
		logic [7:0]         b;
		int                 ch;
		int                 k;
		int                 roll;
		roll = $urandom_range(99);
		w.error_bit = 1'($urandom_range(1));
		w.seq_counter = 3'($urandom_range(7));
		if (roll < 8) begin
			w.payload_bytes = 24'($urandom);
			w.start_bit = 1'($urandom_range(1));
			w.channel_tag = 3'($urandom_range(7));
			return w;
		end
		ch = (roll < 60) ? focus_ch : $urandom_range(tsd_pkg::CHANNEL_COUNT - 1);
		w.channel_tag = 3'(ch + 1);
		w.start_bit = ($urandom_range(99) < 75);
		pos = board.sync_position[ch];
		for (k = 0; k < tsd_pkg::BYTES_PER_WORD; k++) begin
			b = 8'($urandom_range(255));
			if (pos == 0) begin
				if ($urandom_range(99) < 70)
					b = tsd_pkg::SYNC_BYTE;
				if (b == tsd_pkg::SYNC_BYTE && w.start_bit)
					pos = 8'd1;
			end else begin
				pos = (pos + 1 >= tsd_pkg::PACKET_BYTES) ? 8'd0 : pos + 8'd1;
			end
			w.payload_bytes[23 - 8 * k -: 8] = b;
		end
		return w;
	endfunction

	// Offers one word, after an optional gap, and waits until it is taken.
	task automatic send_word(tsd_pkg::pkt_word_t w);
		if ($urandom_range(99) < tx_idle_pct) begin
			pkt_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		pkt <= w;
		pkt_valid <= 1'b1;
		do @(posedge clk); while (pkt_stall);
		board.note_word(w);
	endtask

	// Stops offering words until every owed byte is out and the queue is idle.
	task automatic wait_drained();
		pkt_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_enable_mask(logic [tsd_pkg::MASK_W-1:0] mask);
		cfg_data <= mask;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.enable_mask = mask;
	endtask

	task automatic run_random(int count, int focus_ch, int hold_at, int pause_at);
		int                 i;
		tsd_pkg::pkt_word_t w;
		for (i = 0; i < count; i++) begin
			if (i == hold_at)
				hold_requests++;
			if (i == pause_at)
				wait_drained();
			w = make_packet_word(focus_ch);
			send_word(w);
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		pkt_valid = 1'b0;
		pkt = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: dropped tags, sync with and without start, sync in
		// each byte slot, and the extremes of every field.
		write_enable_mask(4'hF);
		send_word(pack_word(24'h474747, 1'b1, 3'd0, 1'b0, 3'd0));
		send_word(pack_word(24'h474747, 1'b1, 3'd5, 1'b1, 3'd7));
		send_word(pack_word(24'h474747, 1'b1, 3'd6, 1'b0, 3'd3));
		send_word(pack_word(24'hFFFFFF, 1'b1, 3'd7, 1'b1, 3'd5));
		send_word(pack_word(24'h474747, 1'b0, 3'd1, 1'b0, 3'd0));
		send_word(pack_word(24'h000000, 1'b1, 3'd1, 1'b1, 3'd7));
		send_word(pack_word(24'h474747, 1'b1, 3'd1, 1'b1, 3'd7));
		send_word(pack_word(24'h1247FF, 1'b1, 3'd2, 1'b0, 3'd1));
		send_word(pack_word(24'hFFFF47, 1'b1, 3'd3, 1'b1, 3'd2));
		send_word(pack_word(24'h470000, 1'b1, 3'd4, 1'b0, 3'd6));
		send_word(pack_word(24'hFFFFFF, 1'b0, 3'd1, 1'b0, 3'd0));
		send_word(pack_word(24'h000000, 1'b0, 3'd2, 1'b1, 3'd4));
		send_word(pack_word(24'h474747, 1'b0, 3'd0, 1'b0, 3'd7));
		wait_drained();

		// Sender idles little, receiver much; one long hold-off fills the block.
		tx_idle_pct = 8;
		rx_idle_pct = 57;
		run_random(140, $urandom_range(tsd_pkg::CHANNEL_COUNT - 1), 50, -1);

		// All channels disabled: positions still advance.
		wait_drained();
		write_enable_mask(4'h0);
		run_random(30, $urandom_range(tsd_pkg::CHANNEL_COUNT - 1), -1, -1);

		// Partial mask; sender idles much, and pauses until all bytes are out.
		wait_drained();
		write_enable_mask(tsd_pkg::MASK_W'($urandom_range(1, 14)));
		tx_idle_pct = 57;
		rx_idle_pct = 8;
		run_random(120, $urandom_range(tsd_pkg::CHANNEL_COUNT - 1), -1, 60);

		// Full mask, no idling, with another long hold-off.
		wait_drained();
		write_enable_mask(4'hF);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(140, $urandom_range(tsd_pkg::CHANNEL_COUNT - 1), 20, -1);

		wait_drained();
		if (board.mismatch_count == 0)
			$display("[ts_micro_packet_demux_core] OK");
		else
			$display("[ts_micro_packet_demux_core] ERROR");
		$finish;
	end

endmodule
